@@ hdl/bxds_pkg.sv @@
package bxds_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int PIX_W     = 8;
	localparam int HSUM_W    = 10;
	localparam int CSUM_W    = 12;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(640);
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(480);

	// column-sum update issued to the line store on the last pixel of a block's row
	typedef struct packed {
		logic valid;
		logic first_row;
		logic emit;
		logic last_col;
		logic last_row;
	} bxds_op_t;

	typedef struct packed {
		logic [PIX_W-1:0] avg_pixel;
		logic             row_end;
		logic             frame_end;
	} bxds_res_t;

endpackage

@@ hdl/bxds_pix_if.sv @@
interface bxds_pix_if import bxds_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

@@ hdl/bxds_avg_if.sv @@
interface bxds_avg_if import bxds_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] avg_pixel;
	logic             row_end;
	logic             frame_end;

	modport source (output valid, output avg_pixel, output row_end, output frame_end,
		input ready);
	modport sink   (input valid, input avg_pixel, input row_end, input frame_end,
		output ready);
endinterface

@@ hdl/bxds_cfg_if.sv @@
interface bxds_cfg_if import bxds_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/box_downsample_4x4_unit.sv @@
// 4x4 box-filter downsampler for 8-bit grey pixels in raster order.
// pix : input words (pixel, frame_start). frame_start restarts the row and
//       column counters on that pixel; after the last pixel of the frame they
//       wrap on their own.
// avg : one word per full 4x4 block, the block sum divided by 16 (truncated),
//       with row_end on the last block of a block row and frame_end on the
//       last block of the frame. Partial blocks at the right or bottom edge
//       give nothing.
// cfg : register writes (0 = image_width, 1 = image_height), always ready;
//       write only while the block is idle. Values above MAX_WIDTH/HEIGHT clamp.
// Throughput is one pixel per cycle while the output queue has room. A block's
// result leaves after its bottom-right pixel is taken, through the synchronous
// read of the column-sum line store, the read-modify-write and the output queue.
// The two-entry output queue lets input continue while the receiver stalls;
// pix.ready drops only when both entries are spoken for, and at most one
// result arises per four pixels.
// Reset restores 640x480 and clears counters and queue; the line store is not
// cleared, each entry being written on the first row of its block row.
module box_downsample_4x4_unit import bxds_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input logic         clk,
	input logic         arst_n,
	bxds_pix_if.sink    pix,
	bxds_avg_if.source  avg,
	bxds_cfg_if.sink    cfg
);

	localparam int W_W    = $clog2(MAX_WIDTH + 1);
	localparam int H_W    = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int DEPTH  = MAX_WIDTH / 4;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CFG_W-1:0]  width_q, height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [HSUM_W-1:0] hsum_q;

	logic [W_W-1:0]    w_c, w_full, col_x, col_inc, blk_col;
	logic [H_W-1:0]    h_c, h_full, row_x, row_inc, blk_row;
	logic [COL_W-1:0]  col_eff, col_nxt;
	logic [ROW_W-1:0]  row_eff, row_nxt;
	logic [HSUM_W-1:0] hsum_new;
	logic              accept, in_blk;

	bxds_op_t          op;
	logic [ADDR_W-1:0] op_addr;
	logic              res_valid;
	bxds_res_t         res;

	bxds_res_t         q0_q, q1_q;
	logic [1:0]        cnt_q;
	logic              push, pop;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH:  width_q  <= cfg.data;
				REG_IMAGE_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign w_c    = (32'(width_q) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(width_q);
	assign h_c    = (32'(height_q) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT) : H_W'(height_q);
	assign w_full = {w_c[W_W-1:2], 2'b00};
	assign h_full = {h_c[H_W-1:2], 2'b00};

	// position tracking and horizontal sums
	assign accept  = pix.valid && pix.ready;
	assign col_eff = pix.frame_start ? '0 : col_q;
	assign row_eff = pix.frame_start ? '0 : row_q;
	assign col_x   = W_W'(col_eff);
	assign row_x   = H_W'(row_eff);
	assign in_blk  = (col_x < w_full) && (row_x < h_full);
	assign blk_col = col_x >> 2;
	assign blk_row = row_x >> 2;

	assign hsum_new = (col_eff[1:0] == 2'd0) ? HSUM_W'(pix.pixel)
		: hsum_q + HSUM_W'(pix.pixel);

	assign col_inc = col_x + W_W'(1);
	assign row_inc = row_x + H_W'(1);

	always_comb begin
		col_nxt = COL_W'(col_inc);
		row_nxt = row_eff;
		if (col_inc >= w_c) begin
			col_nxt = '0;
			row_nxt = (row_inc >= h_c) ? '0 : ROW_W'(row_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			hsum_q <= '0;
		end else if (accept) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
			if (in_blk) begin
				hsum_q <= hsum_new;
			end else if (pix.frame_start) begin
				hsum_q <= '0;
			end
		end
	end

	assign op.valid     = accept && in_blk && (col_eff[1:0] == 2'd3);
	assign op.first_row = row_eff[1:0] == 2'd0;
	assign op.emit      = row_eff[1:0] == 2'd3;
	assign op.last_col  = (blk_col + W_W'(1)) == (w_c >> 2);
	assign op.last_row  = (blk_row + H_W'(1)) == (h_c >> 2);
	assign op_addr      = ADDR_W'(blk_col);

	bxds_line_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.addr      (op_addr),
		.hsum      (hsum_new),
		.res_valid (res_valid),
		.res       (res)
	);

	// two-entry output queue; an accepted item's result arrives as res_valid in the cycle after
	assign pix.ready = (3'(cnt_q) + 3'(res_valid)) < 3'd2;

	assign push = res_valid;
	assign pop  = avg.valid && avg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					q0_q <= res;
				end else begin
					q1_q <= res;
				end
			end
			2'b01: q0_q <= q1_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					q0_q <= res;
				end else begin
					q0_q <= q1_q;
					q1_q <= res;
				end
			end
			default: ;
		endcase
	end

	assign avg.valid     = cnt_q != 2'd0;
	assign avg.avg_pixel = q0_q.avg_pixel;
	assign avg.row_end   = q0_q.row_end;
	assign avg.frame_end = q0_q.frame_end;

endmodule

@@ hdl/bxds_line_store.sv @@
module bxds_line_store import bxds_pkg::*; #(
	parameter int DEPTH  = DEF_MAX_WIDTH / 4,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bxds_op_t          op,
	input  logic [ADDR_W-1:0] addr,
	input  logic [HSUM_W-1:0] hsum,
	output logic              res_valid,
	output bxds_res_t         res
);

	logic [CSUM_W-1:0] mem [DEPTH];

	bxds_op_t          op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [HSUM_W-1:0] hsum_s1;
	logic [CSUM_W-1:0] rdata_s1;
	logic [CSUM_W-1:0] sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		hsum_s1 <= hsum;
	end

	// Ops to one entry are at least four words apart, so the write-back of s1
	// never meets a read of the same entry: no forwarding path needed.
	always_ff @(posedge clk) begin
		if (op.valid) begin
			rdata_s1 <= mem[addr];
		end
		if (op_s1.valid) begin
			mem[addr_s1] <= sum_s1;
		end
	end

	// first row of a block row overwrites, so stale entries are never used
	assign sum_s1 = op_s1.first_row ? CSUM_W'(hsum_s1) : rdata_s1 + CSUM_W'(hsum_s1);

	assign res_valid     = op_s1.valid && op_s1.emit;
	assign res.avg_pixel = sum_s1[CSUM_W-1:CSUM_W-PIX_W];
	assign res.row_end   = op_s1.last_col;
	assign res.frame_end = op_s1.last_col && op_s1.last_row;

endmodule

@@ hdl/bxds_check.sv @@
module bxds_check import bxds_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             pix_valid,
	input logic             pix_ready,
	input logic             avg_valid,
	input logic             avg_ready,
	input logic [PIX_W-1:0] avg_pixel,
	input logic             row_end,
	input logic             frame_end
);

	// a stalled result word holds
	a_avg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid && !avg_ready |=> avg_valid && $stable(avg_pixel)
			&& $stable(row_end) && $stable(frame_end))
		else $error("result word changed while stalled");

	// frame end is always also a row end
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid && frame_end |-> row_end)
		else $error("frame_end without row_end");

	// a fresh result follows an accepted pixel through the line-store stage and the output queue
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(avg_valid) |-> $past(pix_valid && pix_ready, 2))
		else $error("result without accepted pixel");

	// input back-pressure only while results are queued
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> avg_valid)
		else $error("input stalled with empty output");

endmodule

bind box_downsample_4x4_unit bxds_check u_bxds_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.avg_valid (avg.valid),
	.avg_ready (avg.ready),
	.avg_pixel (avg.avg_pixel),
	.row_end   (avg.row_end),
	.frame_end (avg.frame_end)
);

@@ test/tb_box_downsample_4x4_unit.sv @@
module tb_box_downsample_4x4_unit import bxds_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W        = DEF_MAX_WIDTH;
	localparam int MAX_H        = DEF_MAX_HEIGHT;
	localparam int STORE_DEPTH  = MAX_W / 4;
	localparam int SETTLE       = 8;
	localparam int LIMIT_CYCLES = 1_000_000;

	typedef enum {WORD_PIX, WORD_CFG, WORD_MODE} stim_kind_t;
	typedef enum {FILL_RANDOM, FILL_MAX, FILL_ZERO} fill_t;

	typedef struct {
		stim_kind_t           kind;
		logic [PIX_W-1:0]     pixel;
		logic                 fs;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		int                   send_idle;
		int                   recv_stall;
	} stim_word_t;

	logic clk = 1'b0;
	logic arst_n;

	bxds_pix_if pix();
	bxds_avg_if avg();
	bxds_cfg_if cfg();

	box_downsample_4x4_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.avg    (avg),
		.cfg    (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stim_word_t pending_q[$];
	bxds_res_t  expected_avg_q[$];

	int send_idle      = 0;
	int recv_stall     = 0;
	int quiet_cycles   = 0;
	int cycle_count    = 0;
	int mismatch_count = 0;
	bit stim_done      = 1'b0;

	// shadow of the block's registers and state
	logic [CFG_W-1:0]  model_width  = RST_IMAGE_WIDTH;
	logic [CFG_W-1:0]  model_height = RST_IMAGE_HEIGHT;
	logic [11:0]       model_col    = '0;
	logic [11:0]       model_row    = '0;
	logic [HSUM_W-1:0] model_hsum   = '0;
	logic [CSUM_W-1:0] model_csum [STORE_DEPTH];

	function automatic void write_model_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
		case (idx)
			REG_IMAGE_WIDTH:  model_width = d;
			REG_IMAGE_HEIGHT: model_height = d;
			default: ;
		endcase
	endfunction

	function automatic void predict_pixel(logic [PIX_W-1:0] px, logic fs);
		int unsigned w, h, bw, bh, col, row, b;
		bxds_res_t r;
		w  = (model_width > MAX_W) ? MAX_W : model_width;
		h  = (model_height > MAX_H) ? MAX_H : model_height;
		bw = w / 4;
		bh = h / 4;
		if (fs) begin
			model_col  = '0;
			model_row  = '0;
			model_hsum = '0;
		end
		col = model_col;
		row = model_row;
		if (col < bw * 4 && row < bh * 4) begin
			if (col % 4 == 0)
				model_hsum = HSUM_W'(px);
			else
				model_hsum = model_hsum + px;
			if (col % 4 == 3) begin
				b = (col / 4) % STORE_DEPTH;
				if (row % 4 == 0)
					model_csum[b] = CSUM_W'(model_hsum);
				else
					model_csum[b] = model_csum[b] + model_hsum;
				if (row % 4 == 3) begin
					r.avg_pixel = model_csum[b][CSUM_W-1:4];
					r.row_end   = (col / 4 == bw - 1);
					r.frame_end = r.row_end && (row / 4 == bh - 1);
					expected_avg_q.push_back(r);
				end
			end
		end
		col = col + 1;
		if (col >= w) begin
			col = 0;
			row = row + 1;
			if (row >= h)
				row = 0;
		end
		model_col = 12'(col);
		model_row = 12'(row);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel(fill_t fill);
		case (fill)
			FILL_MAX:  return '1;
			FILL_ZERO: return '0;
			default: begin
				case ($urandom_range(9))
					0: return '0;
					1: return '1;
					default: return PIX_W'($urandom_range(255));
				endcase
			end
		endcase
	endfunction

	task automatic push_pix(logic [PIX_W-1:0] px, logic fs);
		stim_word_t word;
		word = '{kind: WORD_PIX, pixel: px, fs: fs, idx: '0, data: '0,
			send_idle: 0, recv_stall: 0};
		pending_q.push_back(word);
	endtask

	task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, int d);
		stim_word_t word;
		word = '{kind: WORD_CFG, pixel: '0, fs: 1'b0, idx: idx, data: CFG_W'(d),
			send_idle: 0, recv_stall: 0};
		pending_q.push_back(word);
	endtask

	task automatic push_mode(int si, int rs);
		stim_word_t word;
		word = '{kind: WORD_MODE, pixel: '0, fs: 1'b0, idx: '0, data: '0,
			send_idle: si, recv_stall: rs};
		pending_q.push_back(word);
	endtask

	task automatic push_frame(int w, int h, fill_t fill, bit with_start);
		for (int i = 0; i < w * h; i++)
			push_pix(pick_pixel(fill), with_start && i == 0);
	endtask

	task automatic build_stimulus();
		int send_pct [4];
		int recv_pct [4];
		int count, w, h, choice, len;
		bit force_start;
		send_pct = '{0, 75, 0, 29};
		recv_pct = '{0, 0, 75, 29};

		// reset dimensions: part of a 640-wide row, nothing comes out yet
		push_mode(0, 0);
		for (int i = 0; i < 64; i++)
			push_pix(pick_pixel(FILL_RANDOM), 1'b0);

		// smallest image: full-scale block, then wrap into an all-zero frame
		push_cfg(REG_IMAGE_WIDTH, 4);
		push_cfg(REG_IMAGE_HEIGHT, 4);
		push_frame(4, 4, FILL_MAX, 1'b1);
		push_frame(4, 4, FILL_ZERO, 1'b0);

		// width shrinks mid-frame with the column beyond the new width
		push_cfg(REG_IMAGE_WIDTH, 16);
		push_cfg(REG_IMAGE_HEIGHT, 8);
		for (int i = 0; i < 16 * 5 + 12; i++)
			push_pix(pick_pixel(FILL_RANDOM), i == 0);
		push_cfg(REG_IMAGE_WIDTH, 8);
		for (int i = 0; i < 1 + 16; i++)
			push_pix(pick_pixel(FILL_RANDOM), 1'b0);
		push_frame(8, 8, FILL_RANDOM, 1'b0);

		// too small for any block: positions still run and wrap
		push_cfg(REG_IMAGE_WIDTH, 3);
		push_frame(3, 8, FILL_RANDOM, 1'b1);
		push_frame(3, 8, FILL_RANDOM, 1'b0);
		push_cfg(REG_IMAGE_WIDTH, 0);
		push_cfg(REG_IMAGE_HEIGHT, 0);
		for (int i = 0; i < 10; i++)
			push_pix(pick_pixel(FILL_RANDOM), i == 0);
		push_cfg(REG_IMAGE_WIDTH, 8);
		push_cfg(REG_IMAGE_HEIGHT, 3);
		push_frame(8, 3, FILL_RANDOM, 1'b1);
		push_frame(8, 4, FILL_RANDOM, 1'b0);

		// oversized values clamp to the maximum
		push_cfg(REG_IMAGE_WIDTH, 4);
		push_cfg(REG_IMAGE_HEIGHT, 8191);
		push_frame(4, 8, FILL_RANDOM, 1'b1);
		push_cfg(REG_IMAGE_WIDTH, 8191);
		push_cfg(REG_IMAGE_HEIGHT, 4);
		for (int i = 0; i < 40; i++)
			push_pix(pick_pixel(FILL_RANDOM), i == 0);

		for (int m = 0; m < 4; m++) begin
			push_mode(send_pct[m], recv_pct[m]);
			count = 0;
			while (count < 120) begin
				w = $urandom_range(4, 16);
				h = $urandom_range(4, 8);
				push_cfg(REG_IMAGE_WIDTH, w);
				push_cfg(REG_IMAGE_HEIGHT, h);
				force_start = 1'b1;
				for (int f = $urandom_range(1, 3); f > 0; f--) begin
					choice = $urandom_range(9);
					if (choice < 8) begin
						push_frame(w, h, FILL_RANDOM, force_start || ($urandom_range(1) == 1));
						count += w * h;
						force_start = 1'b0;
					end else if (choice == 8) begin
						// frame cut short, next one restarts
						len = $urandom_range(1, w * h - 1);
						for (int i = 0; i < len; i++)
							push_pix(pick_pixel(FILL_RANDOM), force_start && i == 0);
						count += len;
						force_start = 1'b1;
					end else begin
						// stray frame_start anywhere
						len = $urandom_range(1, 12);
						for (int i = 0; i < len; i++)
							push_pix(pick_pixel(FILL_RANDOM),
								force_start ? (i == 0) : ($urandom_range(3) == 0));
						count += len;
						force_start = 1'b1;
					end
				end
			end
		end
	endtask

	always @(posedge clk) begin : driver
		stim_word_t word;
		bit pix_hold, cfg_hold, stall_set;
		logic next_pv, next_cv;
		int stall_next;
		if (arst_n) begin
			pix_hold  = pix.valid && !pix.ready;
			cfg_hold  = cfg.valid && !cfg.ready;
			stall_set = 1'b0;
			if (pix.valid && pix.ready)
				predict_pixel(pix.pixel, pix.frame_start);
			if (cfg.valid && cfg.ready)
				write_model_reg(cfg.index, cfg.data);
			if (expected_avg_q.size() == 0 && !pix.valid)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			next_pv = pix_hold;
			next_cv = cfg_hold;
			if (!pix_hold && !cfg_hold) begin
				while (pending_q.size() > 0 && pending_q[0].kind == WORD_MODE) begin
					send_idle  = pending_q[0].send_idle;
					stall_next = pending_q[0].recv_stall;
					stall_set  = 1'b1;
					void'(pending_q.pop_front());
				end
				if (pending_q.size() > 0) begin
					word = pending_q[0];
					if (word.kind == WORD_PIX) begin
						if ($urandom_range(99) >= send_idle) begin
							pix.pixel       <= word.pixel;
							pix.frame_start <= word.fs;
							next_pv = 1'b1;
							void'(pending_q.pop_front());
						end
					end else if (quiet_cycles >= SETTLE) begin
						// registers only change once the pipeline has drained
						cfg.index <= word.idx;
						cfg.data  <= word.data;
						next_cv = 1'b1;
						void'(pending_q.pop_front());
					end
				end
				if (!next_pv && !next_cv && pending_q.size() == 0)
					stim_done = 1'b1;
			end
			if (stall_set)
				recv_stall <= stall_next;
			pix.valid <= next_pv;
			cfg.valid <= next_cv;
		end
	end

	always @(posedge clk) begin : monitor
		bxds_res_t exp_r;
		if (arst_n) begin
			if (avg.valid && avg.ready) begin
				if (expected_avg_q.size() == 0) begin
					$display("%0t: unexpected word: expected none, got avg_pixel %0d row_end %0b frame_end %0b",
						$time, avg.avg_pixel, avg.row_end, avg.frame_end);
					mismatch_count++;
				end else begin
					exp_r = expected_avg_q.pop_front();
					if (avg.avg_pixel !== exp_r.avg_pixel) begin
						$display("%0t: avg_pixel expected %0d got %0d",
							$time, exp_r.avg_pixel, avg.avg_pixel);
						mismatch_count++;
					end
					if (avg.row_end !== exp_r.row_end) begin
						$display("%0t: row_end expected %0b got %0b",
							$time, exp_r.row_end, avg.row_end);
						mismatch_count++;
					end
					if (avg.frame_end !== exp_r.frame_end) begin
						$display("%0t: frame_end expected %0b got %0b",
							$time, exp_r.frame_end, avg.frame_end);
						mismatch_count++;
					end
				end
			end
			avg.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("box_downsample_4x4_unit verification failed");
			$finish;
		end
	end

	initial begin
		pix.valid       = 1'b0;
		pix.pixel       = '0;
		pix.frame_start = 1'b0;
		avg.ready       = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = REG_IMAGE_WIDTH;
		cfg.data        = '0;
		arst_n          = 1'b0;
		build_stimulus();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && expected_avg_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && expected_avg_q.size() == 0)
			$display("box_downsample_4x4_unit verification clean");
		else
			$display("box_downsample_4x4_unit verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/bxds_pkg.sv
hdl/bxds_pix_if.sv
hdl/bxds_avg_if.sv
hdl/bxds_cfg_if.sv
hdl/bxds_line_store.sv
hdl/box_downsample_4x4_unit.sv
hdl/bxds_check.sv
test/tb_box_downsample_4x4_unit.sv
